// ----- rtl/lfu_pkg.sv -----
package lfu_pkg;

  localparam int ENTRIES   = 64;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int KEY_W     = 32;
  localparam int DATA_W    = 32;
  localparam int CAP_W     = 7;
  localparam int CAP_CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(64);
  localparam logic [DATA_W-1:0] DATA_MAX  = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] count;
    logic [DATA_W-1:0] stamp;
  } entry_t;

endpackage

// ----- rtl/lfu_cache_hit_counter_unit.sv -----
// Fully associative least-frequently-used cache model. A request key is taken on a rising
// edge with start high and busy low; the block then scans every slot of its entry memory,
// one read a cycle through its single read port, steps through ST_SCAN, ST_LAST and
// ST_WRITE and writes the one changed entry back; a new key may be started in the cycle
// the result is shown. The result (hit and the saturating hit total) is on the ports for
// exactly one cycle with done high and must be taken then. The user must write the
// capacity register with cfg_we only while the block is idle; the block does not enforce
// it. Zero acts as one and values above the number of slots act as the number of slots.
module lfu_cache_hit_counter_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [lfu_pkg::KEY_W-1:0]  request_key,
  input  logic                              cfg_we,
  input  logic        [lfu_pkg::CAP_W-1:0]  cfg_data,
  output logic                              done,
  output logic                              hit,
  output logic        [lfu_pkg::DATA_W-1:0] hit_total
);
  import lfu_pkg::*;

  state_t state, state_next;

  logic [CAP_W-1:0]   capacity;
  logic [ENTRIES-1:0] valid;
  logic [DATA_W-1:0]  stamp_counter;
  logic [DATA_W-1:0]  hits_so_far;
  logic [KEY_W-1:0]   req_key;

  // Scan side: read address and the compare stage that follows it in the next cycle.
  logic [IDX_W-1:0] rd_addr;
  logic             cmp_vld;
  logic [IDX_W-1:0] cmp_idx;
  logic             cmp_valid_bit;

  // Scan results.
  logic [CNT_W-1:0]  used;
  logic              found_f;
  logic [IDX_W-1:0]  found_idx;
  logic [DATA_W-1:0] found_count;
  logic              victim_f;
  logic [IDX_W-1:0]  victim_idx;
  logic [DATA_W-1:0] vcount;
  logic [DATA_W-1:0] vage;
  logic              free_f;
  logic [IDX_W-1:0]  free_idx;

  // Entry memory.
  entry_t           mem [ENTRIES];
  entry_t           rdata;
  entry_t           wdata;
  logic             mem_we;
  logic [IDX_W-1:0] waddr;
  logic             issue;
  logic             accept;

  logic [DATA_W-1:0]    age;
  logic                 better;
  logic [CAP_CMP_W-1:0] eff_cap;
  logic                 evict;
  logic                 slot_ok;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[rd_addr];
  end

  assign accept = start && !busy;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept) state_next = ST_SCAN;
      ST_SCAN:  if (rd_addr == IDX_W'(ENTRIES - 1)) state_next = ST_LAST;
      ST_LAST:  state_next = ST_WRITE;
      ST_WRITE: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy  = 1'b1;
    issue = 1'b0;
    case (state)
      ST_IDLE:  busy  = 1'b0;
      ST_SCAN:  issue = 1'b1;
      ST_LAST:  issue = 1'b0;
      ST_WRITE: issue = 1'b0;
      default:  busy  = 1'b1;
    endcase
  end

  assign age    = stamp_counter - rdata.stamp;
  assign better = !victim_f || (rdata.count < vcount) ||
                  ((rdata.count == vcount) && (age < vage));

  always_comb begin
    eff_cap = CAP_CMP_W'(capacity);
    if (capacity == '0) begin
      eff_cap = CAP_CMP_W'(1);
    end else if (CAP_CMP_W'(capacity) > CAP_CMP_W'(ENTRIES)) begin
      eff_cap = CAP_CMP_W'(ENTRIES);
    end
  end

  assign evict   = (CAP_CMP_W'(used) >= eff_cap) && victim_f;
  assign slot_ok = found_f || evict || free_f;
  assign mem_we  = (state == ST_WRITE) && slot_ok;

  always_comb begin
    wdata.key   = req_key;
    wdata.stamp = stamp_counter;
    wdata.count = DATA_W'(1);
    waddr       = free_idx;
    if (found_f) begin
      waddr       = found_idx;
      wdata.count = (found_count == DATA_MAX) ? found_count : found_count + DATA_W'(1);
    end else if (evict) begin
      waddr = victim_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      capacity      <= CAP_RESET;
      valid         <= '0;
      stamp_counter <= '0;
      hits_so_far   <= '0;
      done          <= 1'b0;
      cmp_vld       <= 1'b0;
      rd_addr       <= '0;
    end else begin
      state   <= state_next;
      done    <= 1'b0;
      cmp_vld <= issue;
      if (cfg_we) begin
        capacity <= cfg_data;
      end
      if (accept) begin
        rd_addr <= '0;
      end else if (issue) begin
        rd_addr <= rd_addr + IDX_W'(1);
      end
      if (state == ST_WRITE) begin
        done          <= 1'b1;
        stamp_counter <= stamp_counter + DATA_W'(1);
        if (found_f) begin
          if (hits_so_far != DATA_MAX) begin
            hits_so_far <= hits_so_far + DATA_W'(1);
          end
        end else if (slot_ok) begin
          // An evicted slot is refilled at once, so it simply stays valid.
          valid[waddr] <= 1'b1;
        end
      end
    end
  end

  // Scan payload registers; flags and used count are cleared at the start of every beat.
  always_ff @(posedge clk) begin
    cmp_idx       <= rd_addr;
    cmp_valid_bit <= valid[rd_addr];
    if (accept) begin
      req_key  <= request_key;
      used     <= '0;
      found_f  <= 1'b0;
      victim_f <= 1'b0;
      free_f   <= 1'b0;
    end else if (cmp_vld) begin
      if (cmp_valid_bit) begin
        used <= used + CNT_W'(1);
        if (!found_f && (rdata.key == req_key)) begin
          found_f     <= 1'b1;
          found_idx   <= cmp_idx;
          found_count <= rdata.count;
        end
        if (better) begin
          victim_f   <= 1'b1;
          victim_idx <= cmp_idx;
          vcount     <= rdata.count;
          vage       <= age;
        end
      end else if (!free_f) begin
        free_f   <= 1'b1;
        free_idx <= cmp_idx;
      end
    end
    if (state == ST_WRITE) begin
      hit <= found_f;
    end
  end

  assign hit_total = hits_so_far;

  a_done_after_write: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_WRITE))
    else $error("result strobe without a write-back cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && (rd_addr == '0))
    else $error("accepted beat did not start a scan from slot zero");

  a_hit_total_nonzero: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> (hit_total != '0))
    else $error("hit reported with a zero hit total");

  a_compare_in_scan: assert property (@(posedge clk) disable iff (rst)
    cmp_vld |-> ((state == ST_SCAN) || (state == ST_LAST)))
    else $error("compare stage active outside the scan");

endmodule
